// ===== rtl/event_script_bytecode_sequencer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Event script sequencer assertion macros
// Shared concurrent assertion forms, all disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef EVENT_SCRIPT_BYTECODE_SEQUENCER_CORE_ASSERT_SVH
`define EVENT_SCRIPT_BYTECODE_SEQUENCER_CORE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define ESBS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("esbs: invariant violated");

// antecedent implies consequent in the same cycle
`define ESBS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("esbs: implication violated");

`endif

// ===== rtl/esbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event script sequencer package
// Command, opcode, result codes and shared types of the sequencer.
// ----------------------------------------------------------------------------
package esbs_pkg;

    // input commands
    localparam logic [2:0] CMD_START  = 3'd0;
    localparam logic [2:0] CMD_STEP   = 3'd1;
    localparam logic [2:0] CMD_BYTE   = 3'd2;
    localparam logic [2:0] CMD_CHOICE = 3'd3;
    localparam logic [2:0] CMD_WAIT   = 3'd4;

    // opcodes
    localparam logic [7:0] OP_END    = 8'h00;
    localparam logic [7:0] OP_TEXT   = 8'h01;
    localparam logic [7:0] OP_SET    = 8'h02;
    localparam logic [7:0] OP_CLEAR  = 8'h03;
    localparam logic [7:0] OP_JUMP   = 8'h04;
    localparam logic [7:0] OP_IF     = 8'h05;
    localparam logic [7:0] OP_CHOICE = 8'h06;
    localparam logic [7:0] OP_WAIT   = 8'h07;
    localparam logic [7:0] OP_CALL   = 8'h08;

    // result kinds
    localparam logic [1:0] KIND_FETCH  = 2'd0;
    localparam logic [1:0] KIND_TEXT   = 2'd1;
    localparam logic [1:0] KIND_CHOICE = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    // step status
    localparam logic [1:0] STAT_YIELD = 2'd0;
    localparam logic [1:0] STAT_WAIT  = 2'd1;
    localparam logic [1:0] STAT_ENDED = 2'd2;

    // no choice made yet / cancelled
    localparam logic [7:0] CHOICE_NONE = 8'hFF;

    // operand position tracking: idle, opcode awaited, operand 0..4 awaited
    localparam logic [2:0] IDX_IDLE   = 3'd0;
    localparam logic [2:0] IDX_OPCODE = 3'd1;
    localparam logic [2:0] IDX_OPND0  = 3'd2;
    localparam logic [2:0] IDX_MAX    = 3'd6;
    localparam logic [2:0] POS_LAST   = 3'd4;

    // flag store row geometry
    localparam int FLAG_ROW_BITS = 32;
    localparam int FLAG_SEL_W    = 5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  bank;
        logic [15:0] address;
        logic [7:0]  choice_count;
        logic [1:0]  status;
        logic [7:0]  last_choice;
    } t_result;

    // flag store request: rd loads the bit for a later test, wr does set/clear
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic        val;
        logic [15:0] id;
    } t_flag_req;

    // operand byte count per opcode, zero for end and unknown codes
    function automatic logic [2:0] operand_count(input logic [7:0] opc);
        logic [2:0] n;
        unique case (opc)
            OP_TEXT, OP_JUMP, OP_CHOICE, OP_CALL: n = 3'd3;
            OP_SET, OP_CLEAR:                     n = 3'd2;
            OP_IF:                                n = 3'd5;
            OP_WAIT:                              n = 3'd1;
            default:                              n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/esbs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event script sequencer channels
// Valid/ready channels for command words in and result words out.
// ----------------------------------------------------------------------------
interface esbs_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  start_bank;
    logic [15:0] start_address;
    logic [7:0]  data_byte;

    modport source(output valid, cmd, start_bank, start_address, data_byte, input ready);
    modport sink(input valid, cmd, start_bank, start_address, data_byte, output ready);
endinterface

interface esbs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  bank;
    logic [15:0] address;
    logic [7:0]  choice_count;
    logic [1:0]  status;
    logic [7:0]  last_choice;

    modport source(output valid, kind, bank, address, choice_count, status, last_choice,
                   input ready);
    modport sink(input valid, kind, bank, address, choice_count, status, last_choice,
                 output ready);
endinterface

// ===== rtl/esbs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module esbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/esbs_flag_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event script flag store
// Flag bits in 32-bit RAM rows: clearing sweep after reset, read-modify-write
// for set/clear, and a registered bit lookup for conditional jumps.
// ----------------------------------------------------------------------------
`include "event_script_bytecode_sequencer_core_assert.svh"

module esbs_flag_store import esbs_pkg::*; #(
    parameter int FLAG_COUNT = 2048
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_flag_req i_req,
    output logic      o_bit,
    output logic      o_busy
);

    localparam int ROWS  = (FLAG_COUNT + FLAG_ROW_BITS - 1) / FLAG_ROW_BITS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [16:0] FLAG_LIMIT = 17'(FLAG_COUNT);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    logic                     r_clr_busy;
    logic [ROW_W-1:0]         r_clr_row;
    logic                     r_rd_pend;
    logic                     r_wr_pend;
    logic [FLAG_SEL_W-1:0]    r_sel;
    logic [ROW_W-1:0]         r_row;
    logic                     r_val;
    logic                     r_inrange;
    logic                     r_bit;

    logic                     ram_we;
    logic [ROW_W-1:0]         ram_waddr;
    logic [FLAG_ROW_BITS-1:0] ram_wdata;
    logic                     ram_re;
    logic [ROW_W-1:0]         ram_raddr;
    logic [FLAG_ROW_BITS-1:0] ram_rdata;
    logic                     req_inrange;

    assign req_inrange = ({1'b0, i_req.id} < FLAG_LIMIT);

    // read port: row of the requested id
    assign ram_re    = i_req.rd || i_req.wr;
    assign ram_raddr = i_req.id[FLAG_SEL_W +: ROW_W];

    // write port: clearing sweep, else write-back of the modified row
    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_row;
            ram_wdata = '0;
        end else begin
            ram_we    = r_wr_pend && r_inrange;
            ram_waddr = r_row;
            ram_wdata = (ram_rdata & ~(FLAG_ROW_BITS'(1) << r_sel))
                      | (FLAG_ROW_BITS'(r_val) << r_sel);
        end
    end

    esbs_ram #(
        .WIDTH(FLAG_ROW_BITS),
        .DEPTH(ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control: clearing sweep and pending access marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
            r_rd_pend  <= 1'b0;
            r_wr_pend  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_row == ROW_LAST) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_row <= r_clr_row + ROW_W'(1);
            end
            r_rd_pend <= i_req.rd;
            r_wr_pend <= i_req.wr;
        end
    end

    // access details are registered together with the RAM read
    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_sel     <= i_req.id[FLAG_SEL_W-1:0];
            r_row     <= ram_raddr;
            r_val     <= i_req.val;
            r_inrange <= req_inrange;
        end
        if (r_rd_pend) begin
            r_bit <= r_inrange && ram_rdata[r_sel];
        end
    end

    assign o_bit  = r_bit;
    assign o_busy = r_clr_busy;

    `ESBS_ASSERT_IMPLY(a_no_req_in_clear, i_clk, i_rst_n, r_clr_busy, !(i_req.rd || i_req.wr))
    `ESBS_ASSERT_IMPLY(a_no_row_overlap, i_clk, i_rst_n, ram_we && ram_re, ram_waddr != ram_raddr)

endmodule

// ===== rtl/esbs_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event script result buffer
// Output register plus one skid entry between sequencer and result channel.
// ----------------------------------------------------------------------------
`include "event_script_bytecode_sequencer_core_assert.svh"

module esbs_out_buf import esbs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_result          i_data,
    output logic             o_ready,
    esbs_out_if.source       o_out
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_data;
    t_result r_skid_data;
    logic    take;
    logic    out_free;

    assign take     = r_out_valid && o_out.ready;
    assign out_free = !r_out_valid || take;
    assign o_ready  = !r_skid_valid;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_valid;
            r_skid_valid <= 1'b0;
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // result words
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (i_valid) begin
            r_skid_data <= i_data;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out_data.kind;
    assign o_out.bank         = r_out_data.bank;
    assign o_out.address      = r_out_data.address;
    assign o_out.choice_count = r_out_data.choice_count;
    assign o_out.status       = r_out_data.status;
    assign o_out.last_choice  = r_out_data.last_choice;

    `ESBS_ASSERT_IMPLY(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)

endmodule

// ===== rtl/event_script_bytecode_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event script bytecode sequencer
// Walks a banked bytecode stream one fetched byte per command word.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries command words (start, frame step, fetched byte, choice
//   answer, set wait). o_out carries at most one result word per command:
//   fetch request, text print request, choice request or step finished.
//   Result words are registered in the result buffer before o_out. Throughput:
//   one command word per cycle while i_in.ready is high; each word does
//   its control update in the accept cycle and any flag read-modify-write
//   in the RAM over the accept cycle and the next.
//   Reset: i_in.ready stays low while the flag RAM is swept to zero, one
//   32-bit row per cycle.
//   Stall: the output register and one skid entry hold results; with both
//   full, i_in.ready drops until o_out.ready takes a word.
//   Flag ids at or above FLAG_COUNT are ignored on set/clear and read as 0.
// ----------------------------------------------------------------------------
`include "event_script_bytecode_sequencer_core_assert.svh"

module event_script_bytecode_sequencer_core import esbs_pkg::*; #(
    parameter int FLAG_COUNT = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    esbs_in_if.sink     i_in,
    esbs_out_if.source  o_out
);

    logic        r_running,   n_running;
    logic [7:0]  r_prog_bank, n_prog_bank;
    logic [15:0] r_prog_addr, n_prog_addr;
    logic [7:0]  r_wait_left, n_wait_left;
    logic [7:0]  r_choice_seen, n_choice_seen;
    logic        r_ret_valid, n_ret_valid;
    logic [7:0]  r_ret_bank,  n_ret_bank;
    logic [15:0] r_ret_addr,  n_ret_addr;
    logic [7:0]  r_cur_opcode, n_cur_opcode;
    logic [2:0]  r_op_index,  n_op_index;
    logic [39:0] r_op_bytes,  n_op_bytes;

    logic        fire;
    logic        flag_busy;
    logic        flag_bit;
    logic        buf_ready;
    t_flag_req   flag_req;
    logic        res_valid;
    t_result     res;

    logic        v_exec;
    logic        v_fetch;
    logic        v_fin;
    logic [1:0]  v_status;
    logic [7:0]  v_opc;
    logic [39:0] v_ops;
    logic [2:0]  v_pos;
    logic [7:0]  b;

    assign i_in.ready = buf_ready && !flag_busy;
    assign fire       = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;

    // command decode, operand collection and opcode execution
    always_comb begin
        n_running     = r_running;
        n_prog_bank   = r_prog_bank;
        n_prog_addr   = r_prog_addr;
        n_wait_left   = r_wait_left;
        n_choice_seen = r_choice_seen;
        n_ret_valid   = r_ret_valid;
        n_ret_bank    = r_ret_bank;
        n_ret_addr    = r_ret_addr;
        n_cur_opcode  = r_cur_opcode;
        n_op_index    = r_op_index;
        n_op_bytes    = r_op_bytes;
        v_exec        = 1'b0;
        v_fetch       = 1'b0;
        v_fin         = 1'b0;
        v_status      = STAT_YIELD;
        v_opc         = r_cur_opcode;
        v_ops         = r_op_bytes;
        v_pos         = r_op_index - IDX_OPND0;
        flag_req      = '0;
        res_valid     = 1'b0;
        res           = '0;
        res.last_choice = r_choice_seen;

        if (v_pos > POS_LAST) begin
            v_pos = POS_LAST;
        end

        if (fire) begin
            unique case (i_in.cmd)
                CMD_START: begin
                    n_running     = 1'b1;
                    n_prog_bank   = i_in.start_bank;
                    n_prog_addr   = i_in.start_address;
                    n_wait_left   = '0;
                    n_choice_seen = CHOICE_NONE;
                    n_ret_valid   = 1'b0;
                    n_op_index    = IDX_IDLE;
                    n_op_bytes    = '0;
                end
                CMD_STEP: begin
                    if (!r_running) begin
                        v_fin    = 1'b1;
                        v_status = STAT_ENDED;
                    end else if (r_op_index != IDX_IDLE) begin
                        v_fetch = 1'b1;
                    end else if (r_wait_left != 8'd0) begin
                        n_wait_left = r_wait_left - 8'd1;
                        v_fin       = 1'b1;
                        v_status    = STAT_WAIT;
                    end else begin
                        n_op_index = IDX_OPCODE;
                        v_fetch    = 1'b1;
                    end
                end
                CMD_BYTE: begin
                    if (r_running && r_op_index != IDX_IDLE) begin
                        n_prog_addr = r_prog_addr + 16'd1;
                        if (r_op_index == IDX_OPCODE) begin
                            n_cur_opcode = b;
                            n_op_bytes   = '0;
                            v_opc        = b;
                            v_ops        = '0;
                            if (operand_count(b) == 3'd0) begin
                                v_exec = 1'b1;
                            end else begin
                                n_op_index = IDX_OPND0;
                                v_fetch    = 1'b1;
                            end
                        end else begin
                            v_ops      = r_op_bytes | (40'(b) << {v_pos, 3'b000});
                            n_op_bytes = v_ops;
                            if (r_cur_opcode == OP_JUMP && v_pos == 3'd0) begin
                                n_prog_bank = b;
                            end
                            // conditional jump: look up the flag once the id is complete
                            if (r_cur_opcode == OP_IF && v_pos == 3'd1) begin
                                flag_req.rd = 1'b1;
                                flag_req.id = v_ops[15:0];
                            end
                            if (v_pos + 3'd1 >= operand_count(r_cur_opcode)) begin
                                v_exec = 1'b1;
                            end else begin
                                n_op_index = r_op_index + 3'd1;
                                v_fetch    = 1'b1;
                            end
                        end
                    end
                end
                CMD_CHOICE: n_choice_seen = b;
                CMD_WAIT:   n_wait_left   = b;
                default: ;
            endcase
        end

        // opcode execution on its last byte
        if (v_exec) begin
            unique case (v_opc)
                OP_END: begin
                    if (r_ret_valid) begin
                        n_prog_bank = r_ret_bank;
                        n_prog_addr = r_ret_addr;
                        n_ret_valid = 1'b0;
                        n_op_index  = IDX_OPCODE;
                        v_fetch     = 1'b1;
                    end else begin
                        n_running = 1'b0;
                        v_fin     = 1'b1;
                        v_status  = STAT_ENDED;
                    end
                end
                OP_TEXT: begin
                    n_op_index  = IDX_IDLE;
                    res_valid   = 1'b1;
                    res.kind    = KIND_TEXT;
                    res.bank    = v_ops[7:0];
                    res.address = v_ops[23:8];
                end
                OP_SET, OP_CLEAR: begin
                    flag_req.wr  = 1'b1;
                    flag_req.val = (v_opc == OP_SET);
                    flag_req.id  = v_ops[15:0];
                    n_op_index   = IDX_OPCODE;
                    v_fetch      = 1'b1;
                end
                OP_JUMP: begin
                    n_prog_addr = v_ops[23:8];
                    n_op_index  = IDX_OPCODE;
                    v_fetch     = 1'b1;
                end
                OP_IF: begin
                    if (flag_bit) begin
                        n_prog_bank = v_ops[23:16];
                        n_prog_addr = v_ops[39:24];
                    end
                    n_op_index = IDX_OPCODE;
                    v_fetch    = 1'b1;
                end
                OP_CHOICE: begin
                    n_op_index       = IDX_IDLE;
                    res_valid        = 1'b1;
                    res.kind         = KIND_CHOICE;
                    res.bank         = n_prog_bank;
                    res.address      = v_ops[23:8];
                    res.choice_count = v_ops[7:0];
                end
                OP_WAIT: begin
                    n_wait_left = v_ops[7:0];
                    v_fin       = 1'b1;
                    v_status    = STAT_WAIT;
                end
                OP_CALL: begin
                    if (!r_ret_valid) begin
                        n_ret_bank = n_prog_bank;
                        n_ret_addr = n_prog_addr;
                    end
                    n_ret_valid = 1'b1;
                    n_prog_bank = v_ops[7:0];
                    n_prog_addr = v_ops[23:8];
                    n_op_index  = IDX_OPCODE;
                    v_fetch     = 1'b1;
                end
                default: begin
                    n_running = 1'b0;
                    v_fin     = 1'b1;
                    v_status  = STAT_ENDED;
                end
            endcase
        end

        // result word assembly
        if (v_fetch) begin
            res_valid   = 1'b1;
            res.kind    = KIND_FETCH;
            res.bank    = n_prog_bank;
            res.address = n_prog_addr;
        end else if (v_fin) begin
            n_op_index  = IDX_IDLE;
            res_valid   = 1'b1;
            res.kind    = KIND_DONE;
            res.status  = v_status;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running     <= 1'b0;
            r_prog_bank   <= '0;
            r_prog_addr   <= '0;
            r_wait_left   <= '0;
            r_choice_seen <= CHOICE_NONE;
            r_ret_valid   <= 1'b0;
            r_ret_bank    <= '0;
            r_ret_addr    <= '0;
            r_cur_opcode  <= '0;
            r_op_index    <= IDX_IDLE;
            r_op_bytes    <= '0;
        end else begin
            r_running     <= n_running;
            r_prog_bank   <= n_prog_bank;
            r_prog_addr   <= n_prog_addr;
            r_wait_left   <= n_wait_left;
            r_choice_seen <= n_choice_seen;
            r_ret_valid   <= n_ret_valid;
            r_ret_bank    <= n_ret_bank;
            r_ret_addr    <= n_ret_addr;
            r_cur_opcode  <= n_cur_opcode;
            r_op_index    <= n_op_index;
            r_op_bytes    <= n_op_bytes;
        end
    end

    esbs_flag_store #(
        .FLAG_COUNT(FLAG_COUNT)
    ) u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (flag_req),
        .o_bit   (flag_bit),
        .o_busy  (flag_busy)
    );

    esbs_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (res),
        .o_ready (buf_ready),
        .o_out   (o_out)
    );

    `ESBS_ASSERT_IMPLY(a_index_needs_run, i_clk, i_rst_n, r_op_index != IDX_IDLE, r_running)
    `ESBS_ASSERT_ALWAYS(a_index_range, i_clk, i_rst_n, r_op_index <= IDX_MAX)

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event script sequencer testbench
// Plays host to the sequencer: starts scripts, steps frames and feeds the
// bytes of well-formed random scripts, mixed with stray commands. A
// scoreboard tracks program counter, flags, return slot and wait count on
// its own, and compares every result word with its prediction in order.
// ----------------------------------------------------------------------------
module tb;
    import esbs_pkg::*;

    localparam int FLAG_COUNT   = 2048;
    localparam int RANDOM_WORDS = 1450;
    localparam int STALL_LIMIT  = 4000;
    localparam int PRINT_LIMIT  = 20;

    // command codes the block ignores
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    // an opcode outside the defined set
    localparam logic [7:0] OP_UNKNOWN = 8'hFF;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  bank;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_cmd_word;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of the sequencer state and the expected results
    // ------------------------------------------------------------------------
    class script_scoreboard;
        t_result     expected_results[$];
        int          errors;
        int          checked;
        int          accepted;
        int          effective_words;
        int          kind_seen[4];

        bit          running;
        logic [7:0]  pc_bank;
        logic [15:0] pc_addr;
        logic [7:0]  wait_left;
        logic [7:0]  choice_seen;
        bit          ret_valid;
        logic [7:0]  ret_bank;
        logic [15:0] ret_addr;
        bit          flag_bits[FLAG_COUNT];
        logic [7:0]  cur_op;
        logic [2:0]  slot;
        logic [39:0] operands;

        function new();
            errors = 0;
            checked = 0;
            accepted = 0;
            effective_words = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
            running = 0;
            pc_bank = '0;
            pc_addr = '0;
            wait_left = '0;
            choice_seen = CHOICE_NONE;
            ret_valid = 0;
            ret_bank = '0;
            ret_addr = '0;
            foreach (flag_bits[i]) flag_bits[i] = 0;
            cur_op = '0;
            slot = IDX_IDLE;
            operands = '0;
        endfunction

        function void expect_result(logic [1:0] kind, logic [7:0] bank, logic [15:0] addr,
                                    logic [7:0] count, logic [1:0] status);
            t_result r;
            r.kind = kind;
            r.bank = bank;
            r.address = addr;
            r.choice_count = count;
            r.status = status;
            r.last_choice = choice_seen;
            expected_results.push_back(r);
        endfunction

        function void expect_fetch();
            expect_result(KIND_FETCH, pc_bank, pc_addr, 8'd0, STAT_YIELD);
        endfunction

        function void expect_done(logic [1:0] status);
            slot = IDX_IDLE;
            expect_result(KIND_DONE, 8'd0, 16'd0, 8'd0, status);
        endfunction

        function void next_opcode();
            slot = IDX_OPCODE;
            expect_fetch();
        endfunction

        function int operand_len(logic [7:0] op);
            case (op)
                OP_TEXT, OP_JUMP, OP_CHOICE, OP_CALL: return 3;
                OP_SET, OP_CLEAR:                     return 2;
                OP_IF:                                return 5;
                OP_WAIT:                              return 1;
                default:                              return 0;
            endcase
        endfunction

        function logic [7:0] opnd(int i);
            return operands[8*i +: 8];
        endfunction

        function logic [15:0] opnd_word(int i);
            return {opnd(i + 1), opnd(i)};
        endfunction

        // execute the opcode once all its operand bytes are in
        function void run_opcode();
            int id;
            id = int'(opnd_word(0));
            case (cur_op)
                OP_END: begin
                    if (ret_valid) begin
                        pc_bank = ret_bank;
                        pc_addr = ret_addr;
                        ret_valid = 0;
                        next_opcode();
                    end else begin
                        running = 0;
                        expect_done(STAT_ENDED);
                    end
                end
                OP_TEXT: begin
                    slot = IDX_IDLE;
                    expect_result(KIND_TEXT, opnd(0), opnd_word(1), 8'd0, STAT_YIELD);
                end
                OP_SET, OP_CLEAR: begin
                    if (id < FLAG_COUNT) flag_bits[id] = (cur_op == OP_SET);
                    next_opcode();
                end
                OP_JUMP: begin
                    pc_addr = opnd_word(1);
                    next_opcode();
                end
                OP_IF: begin
                    if (id < FLAG_COUNT && flag_bits[id]) begin
                        pc_bank = opnd(2);
                        pc_addr = opnd_word(3);
                    end
                    next_opcode();
                end
                OP_CHOICE: begin
                    slot = IDX_IDLE;
                    expect_result(KIND_CHOICE, pc_bank, opnd_word(1), opnd(0), STAT_YIELD);
                end
                OP_WAIT: begin
                    wait_left = opnd(0);
                    expect_done(STAT_WAIT);
                end
                OP_CALL: begin
                    if (!ret_valid) begin
                        ret_valid = 1;
                        ret_bank = pc_bank;
                        ret_addr = pc_addr;
                    end
                    pc_bank = opnd(0);
                    pc_addr = opnd_word(1);
                    next_opcode();
                end
                default: begin
                    running = 0;
                    expect_done(STAT_ENDED);
                end
            endcase
        endfunction

        // fetched script byte while an opcode or operand is awaited
        function void take_byte(logic [7:0] b);
            int pos;
            pc_addr = pc_addr + 16'd1;
            if (slot == IDX_OPCODE) begin
                cur_op = b;
                operands = '0;
                if (operand_len(b) == 0) begin
                    run_opcode();
                end else begin
                    slot = IDX_OPND0;
                    expect_fetch();
                end
            end else begin
                pos = int'(slot) - int'(IDX_OPND0);
                if (pos > 4) pos = 4;
                operands = operands | (40'(b) << (8 * pos));
                if (cur_op == OP_JUMP && pos == 0) pc_bank = b;
                if (pos + 1 >= operand_len(cur_op)) begin
                    run_opcode();
                end else begin
                    slot = slot + 3'd1;
                    expect_fetch();
                end
            end
        endfunction

        // accepted command word; counts the ones the block does not ignore
        function void apply_command(t_cmd_word w);
            bit ignored;
            ignored = 0;
            accepted++;
            case (w.cmd)
                CMD_START: begin
                    running = 1;
                    pc_bank = w.bank;
                    pc_addr = w.addr;
                    wait_left = '0;
                    choice_seen = CHOICE_NONE;
                    ret_valid = 0;
                    slot = IDX_IDLE;
                    operands = '0;
                end
                CMD_STEP: begin
                    if (!running) begin
                        expect_done(STAT_ENDED);
                    end else if (slot != IDX_IDLE) begin
                        expect_fetch();
                    end else if (wait_left != 0) begin
                        wait_left = wait_left - 8'd1;
                        expect_done(STAT_WAIT);
                    end else begin
                        next_opcode();
                    end
                end
                CMD_BYTE: begin
                    if (!running || slot == IDX_IDLE) ignored = 1;
                    else take_byte(w.data);
                end
                CMD_CHOICE: choice_seen = w.data;
                CMD_WAIT:   wait_left = w.data;
                default:    ignored = 1;
            endcase
            if (!ignored) effective_words++;
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result word kind %0d", got.kind));
                return;
            end
            want = expected_results.pop_front();
            checked++;
            kind_seen[got.kind]++;
            if (got.kind !== want.kind)
                report_mismatch($sformatf("word %0d kind %0d, expected %0d",
                                          checked, got.kind, want.kind));
            if (got.bank !== want.bank)
                report_mismatch($sformatf("word %0d bank %0h, expected %0h",
                                          checked, got.bank, want.bank));
            if (got.address !== want.address)
                report_mismatch($sformatf("word %0d address %0h, expected %0h",
                                          checked, got.address, want.address));
            if (got.choice_count !== want.choice_count)
                report_mismatch($sformatf("word %0d choice_count %0d, expected %0d",
                                          checked, got.choice_count, want.choice_count));
            if (got.status !== want.status)
                report_mismatch($sformatf("word %0d status %0d, expected %0d",
                                          checked, got.status, want.status));
            if (got.last_choice !== want.last_choice)
                report_mismatch($sformatf("word %0d last_choice %0h, expected %0h",
                                          checked, got.last_choice, want.last_choice));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, channels and block
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    esbs_in_if  cmd_ch ();
    esbs_out_if res_ch ();

    event_script_bytecode_sequencer_core #(
        .FLAG_COUNT(FLAG_COUNT)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_ch),
        .o_out  (res_ch)
    );

    script_scoreboard sb = new();
    logic [15:0] script_id = '0;

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_cmd_word mk_word(logic [2:0] cmd, logic [7:0] bank,
                                          logic [15:0] addr, logic [7:0] data);
        t_cmd_word w;
        w.cmd = cmd;
        w.bank = bank;
        w.addr = addr;
        w.data = data;
        return w;
    endfunction

    function automatic logic [7:0] small_wait();
        return ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    endfunction

    // next script byte, shaped by what the sequencer awaits
    function automatic logic [7:0] script_byte();
        int r;
        int pos;
        r = $urandom_range(0, 99);
        if (sb.slot == IDX_OPCODE) begin
            if (r < 14)      return OP_SET;
            else if (r < 22) return OP_CLEAR;
            else if (r < 36) return OP_IF;
            else if (r < 47) return OP_TEXT;
            else if (r < 56) return OP_CHOICE;
            else if (r < 65) return OP_WAIT;
            else if (r < 73) return OP_JUMP;
            else if (r < 81) return OP_CALL;
            else if (r < 95) return OP_END;
            else             return 8'($urandom_range(int'(OP_CALL) + 1, 255));
        end
        pos = int'(sb.slot) - int'(IDX_OPND0);
        case (sb.cur_op)
            OP_SET, OP_CLEAR, OP_IF: begin
                // flag ids: a small hot pool, the store edge, far out of range or any value
                if (pos == 0) begin
                    if (r < 70)      script_id = 16'($urandom_range(0, 15));
                    else if (r < 80) script_id = 16'($urandom_range(FLAG_COUNT - 8,
                                                                    FLAG_COUNT + 7));
                    else if (r < 90) script_id = 16'($urandom_range(16'hFFF0, 16'hFFFF));
                    else             script_id = 16'($urandom);
                    return script_id[7:0];
                end
                if (pos == 1) return script_id[15:8];
                return 8'($urandom);
            end
            OP_WAIT: return small_wait();
            OP_CHOICE: begin
                if (pos == 0 && r < 10) return 8'd0;
                if (pos == 0 && r < 20) return 8'hFF;
                return 8'($urandom);
            end
            default: return 8'($urandom);
        endcase
    endfunction

    // next command word: mostly a well-formed host, some stray commands
    function automatic t_cmd_word pick_word();
        t_cmd_word w;
        int r;
        w = mk_word(CMD_STEP, 8'($urandom), 16'($urandom), 8'($urandom));
        r = $urandom_range(0, 99);
        if (!sb.running) begin
            if (r < 70) begin
                w.cmd = CMD_START;
                if ($urandom_range(0, 7) == 0) w.addr = 16'hFFFF - 16'($urandom_range(0, 3));
            end else if (r >= 88) begin
                w.cmd = 3'($urandom_range(int'(CMD_BYTE), int'(CMD_UNUSED_HI)));
            end
        end else if (sb.slot == IDX_IDLE) begin
            if (sb.wait_left > 4 && r < 40) begin
                w.cmd = CMD_WAIT;
                w.data = 8'd0;
            end else if (r >= 75 && r < 80) begin
                w.cmd = CMD_CHOICE;
                if ($urandom_range(0, 3) == 0) w.data = CHOICE_NONE;
            end else if (r >= 80 && r < 87) begin
                w.cmd = CMD_WAIT;
                w.data = small_wait();
            end else if (r >= 87 && r < 92) begin
                w.cmd = CMD_BYTE;
            end else if (r >= 92 && r < 96) begin
                w.cmd = 3'($urandom_range(int'(CMD_UNUSED_LO), int'(CMD_UNUSED_HI)));
            end else if (r >= 96) begin
                w.cmd = CMD_START;
            end
        end else begin
            if (r < 88) begin
                w.cmd = CMD_BYTE;
                w.data = script_byte();
            end else if (r >= 93 && r < 96) begin
                w.cmd = CMD_CHOICE;
            end else if (r >= 96 && r < 98) begin
                w.cmd = CMD_WAIT;
                w.data = small_wait();
            end else if (r >= 98) begin
                w.cmd = ($urandom_range(0, 1) == 0) ? CMD_START : CMD_UNUSED_HI;
            end
        end
        return w;
    endfunction

    // present one command word and hold it until accepted
    task automatic send_word(t_cmd_word w);
        cmd_ch.valid         <= 1'b1;
        cmd_ch.cmd           <= w.cmd;
        cmd_ch.start_bank    <= w.bank;
        cmd_ch.start_address <= w.addr;
        cmd_ch.data_byte     <= w.data;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        sb.apply_command(w);
    endtask

    task automatic send_byte(logic [7:0] b);
        send_word(mk_word(CMD_BYTE, 8'h00, 16'h0000, b));
    endtask

    // ------------------------------------------------------------------------
    // result side: checks accepted words, stalls on a changing pattern
    // ------------------------------------------------------------------------
    int stall_mode = 0;
    int stall_left = 0;
    int tick = 0;

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.kind = res_ch.kind;
            got.bank = res_ch.bank;
            got.address = res_ch.address;
            got.choice_count = res_ch.choice_count;
            got.status = res_ch.status;
            got.last_choice = res_ch.last_choice;
            sb.check_result(got);
        end
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(40, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= 1'($urandom_range(0, 1));
            2:       res_ch.ready <= (tick % 5 == 0);
            default: res_ch.ready <= (tick % 24 >= 20);
        endcase
        tick <= tick + 1;
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any word moving on either side
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int base;
        int burst;

        i_rst_n              <= 1'b0;
        cmd_ch.valid         <= 1'b0;
        cmd_ch.cmd           <= CMD_START;
        cmd_ch.start_bank    <= '0;
        cmd_ch.start_address <= '0;
        cmd_ch.data_byte     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: stopped step, address wrap, stray commands, every opcode
        send_word(mk_word(CMD_STEP, 8'h00, 16'h0000, 8'h00));
        send_word(mk_word(CMD_START, 8'hFF, 16'hFFFF, 8'h00));
        send_byte(8'h5A);
        send_word(mk_word(CMD_UNUSED_HI, 8'hFF, 16'hFFFF, 8'hFF));
        send_word(mk_word(CMD_STEP, 8'h00, 16'h0000, 8'h00));
        // step while a fetch is outstanding repeats the request
        send_word(mk_word(CMD_STEP, 8'h00, 16'h0000, 8'h00));
        // set of an id far beyond the store, fetched across the address wrap
        send_byte(OP_SET);
        send_byte(8'hFF);
        send_byte(8'hFF);
        // test of a clear flag falls through
        send_byte(OP_IF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(OP_TEXT);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_word(mk_word(CMD_CHOICE, 8'h00, 16'h0000, 8'h00));
        send_word(mk_word(CMD_WAIT, 8'h00, 16'h0000, 8'h01));
        send_word(mk_word(CMD_STEP, 8'h00, 16'h0000, 8'h00));
        send_word(mk_word(CMD_STEP, 8'h00, 16'h0000, 8'h00));
        send_byte(OP_CALL);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        // clear of the first id past the store
        send_byte(OP_CLEAR);
        send_byte(8'h00);
        send_byte(8'h08);
        send_byte(OP_JUMP);
        send_byte(8'hAB);
        send_byte(8'hCD);
        send_byte(8'hEF);
        // choice with zero entries
        send_byte(OP_CHOICE);
        send_byte(8'h00);
        send_byte(8'h11);
        send_byte(8'h22);
        send_word(mk_word(CMD_STEP, 8'h00, 16'h0000, 8'h00));
        send_byte(OP_WAIT);
        send_byte(8'h00);
        send_word(mk_word(CMD_STEP, 8'h00, 16'h0000, 8'h00));
        // end returns through the slot, then an unknown opcode stops
        send_byte(OP_END);
        send_byte(OP_UNKNOWN);
        send_word(mk_word(CMD_STEP, 8'h00, 16'h0000, 8'h00));

        // random scripts in bursts with gaps
        base = sb.effective_words;
        while (sb.effective_words - base < RANDOM_WORDS) begin
            burst = $urandom_range(1, 32);
            repeat (burst) send_word(pick_word());
            if ($urandom_range(0, 3) != 0) begin
                cmd_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        cmd_ch.valid <= 1'b0;

        // drain, then a few cycles for anything stray
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d command words (%0d taking effect), %0d result words checked",
                 sb.accepted, sb.effective_words, sb.checked);
        $display("results: fetch %0d, text %0d, choice %0d, step finished %0d",
                 sb.kind_seen[KIND_FETCH], sb.kind_seen[KIND_TEXT],
                 sb.kind_seen[KIND_CHOICE], sb.kind_seen[KIND_DONE]);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
